>>> hw/rtl/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg: shared types and constants of the formation setpoint generator
// Payload structs, register indexes, item kinds and CORDIC constants.
// ----------------------------------------------------------------------------
`default_nettype none
package fsg_pkg;

  // item kinds
  localparam logic [1:0] MODE_ACTIVATE = 2'd0;
  localparam logic [1:0] MODE_TARGET   = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_PATTERN      = 3'd0;
  localparam logic [2:0] CFG_DRONE_INDEX  = 3'd1;
  localparam logic [2:0] CFG_DRONE_COUNT  = 3'd2;
  localparam logic [2:0] CFG_ORBIT_RADIUS = 3'd3;
  localparam logic [2:0] CFG_ANGULAR_RATE = 3'd4;

  // cordic constants, q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]        PI_Q30      = 32'd3373259426;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] target_north;
    logic signed [31:0] target_east;
    logic signed [31:0] target_down;
    logic signed [15:0] target_heading;
    logic [15:0]        tick_us;
  } fsg_in_t;

  typedef struct packed {
    logic signed [31:0] set_north;
    logic signed [31:0] set_east;
    logic signed [31:0] set_down;
    logic signed [15:0] set_yaw;
  } fsg_out_t;

  // arctangent of 2^-i in q30 radians
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      5'd30: v = 34'sh000000001;
      default: v = 34'sh000000000;
    endcase
    return v;
  endfunction

  // altitude layer magnitude: 3 m plus 0.3 m per index rounded, q16.16
  function automatic logic [31:0] layer_of(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'd196608;
      4'd1:    v = 32'd216269;
      4'd2:    v = 32'd235930;
      4'd3:    v = 32'd255590;
      4'd4:    v = 32'd275251;
      4'd5:    v = 32'd294912;
      4'd6:    v = 32'd314573;
      4'd7:    v = 32'd334234;
      4'd8:    v = 32'd353894;
      4'd9:    v = 32'd373555;
      4'd10:   v = 32'd393216;
      4'd11:   v = 32'd412877;
      4'd12:   v = 32'd432538;
      4'd13:   v = 32'd452198;
      4'd14:   v = 32'd471859;
      default: v = 32'd491520;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fsg_divider.sv
// ----------------------------------------------------------------------------
// fsg_divider: serial restoring divider for the orbit phase
// Computes (index * 2^32) / count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fsg_divider
  import fsg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [3:0]  idx,
  input  wire logic [4:0]  cnt,
  output logic             done,
  output logic [31:0]      quot
);
  localparam logic [5:0] LAST = 6'd35;

  logic [35:0] num;
  logic [4:0]  rem;
  logic [4:0]  dvs;
  logic [5:0]  step;
  logic        busy;
  logic [5:0]  trial;
  logic        ge;

  // one trial subtract per cycle
  assign trial = {rem, num[35]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = num[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        num  <= {idx, 32'd0};
        rem  <= '0;
        dvs  <= cnt;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 5'(trial - {1'b0, dvs}) : trial[4:0];
        num  <= {num[34:0], ge};
        step <= step + 6'd1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !done |=> busy || done) else $error("divider run lost");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= LAST) else $error("divider step overrun");
endmodule
`default_nettype wire

>>> hw/rtl/fsg_mult.sv
// ----------------------------------------------------------------------------
// fsg_mult: serial signed multiplier
// Shift-add over the 34 bits of a, one bit per cycle, 68-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module fsg_mult
  import fsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [33:0] a,
  input  wire logic signed [33:0] b,
  output logic                    done,
  output logic signed [67:0]      prod
);
  localparam logic [5:0] LAST = 6'd33;

  logic signed [34:0] hi;
  logic [33:0]        lo;
  logic signed [34:0] bx;
  logic [5:0]         step;
  logic               busy;
  logic signed [34:0] addend;
  logic signed [34:0] sum;

  // top bit of a carries negative weight
  always_comb begin
    if (!lo[0])
      addend = '0;
    else if (step == LAST)
      addend = -bx;
    else
      addend = bx;
    sum = hi + addend;
  end

  assign prod = {hi[33:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        hi   <= '0;
        lo   <= a;
        bx   <= 35'(b);
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi   <= {sum[34], sum[34:1]};
        lo   <= {sum[0], lo[33:1]};
        step <= step + 6'd1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("multiplier done without run");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= LAST) else $error("multiplier step overrun");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && step == 6'd0) else $error("multiplier start lost");
endmodule
`default_nettype wire

>>> hw/rtl/fsg_cordic.sv
// ----------------------------------------------------------------------------
// fsg_cordic: iterative rotation CORDIC
// One micro-rotation per cycle, sine and cosine in q2.30.
// ----------------------------------------------------------------------------
`default_nettype none
module fsg_cordic
  import fsg_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [33:0] z0,
  input  wire logic               flip,
  output logic                    done,
  output logic signed [33:0]      cos_q30,
  output logic signed [33:0]      sin_q30
);
  localparam int IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [IW-1:0]      it;
  logic               busy;
  logic               flip_r;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign at = atan_q30(5'(it));

  // half-turn fold undone at the output
  assign cos_q30 = flip_r ? -x : x;
  assign sin_q30 = flip_r ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
      x    <= '0;
      y    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        x      <= CORDIC_GAIN;
        y      <= '0;
        z      <= z0;
        flip_r <= flip;
        it     <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        it <= it + 1'b1;
        if (it == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("cordic done without run");
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && it == '0) else $error("cordic start lost");
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(x) && $stable(y)) else $error("cordic moved idle");
endmodule
`default_nettype wire

>>> hw/rtl/formation_setpoint_generator.sv
// ----------------------------------------------------------------------------
// formation_setpoint_generator: position and yaw setpoints for one drone
// Sequencer around a serial divider, serial multiplier and iterative CORDIC.
// ----------------------------------------------------------------------------
// Use: items arrive on in_valid/in_stall with an fsg_in_t payload. An
// activate item clears elapsed time, a target item stores the target, a
// tick item with a known target produces one fsg_out_t transaction on
// out_valid/out_stall. Other items give no result and do not stall the input.
// Registers are written on cfg_valid/cfg_ready (always ready) by index. The
// user must do so only while the block is idle; the block does not enforce it.
// A tick runs the bit-serial multiplier (three products in orbital, four
// in V-sweep), the iterative CORDIC and, in orbital only, the phase
// divider. One item is in work at a time; in_stall is high while a tick
// is in work, so a new item is accepted only once the tick is done.
// Reset clears registers to their reset values, drops any target and
// output. A stalled result is held in the output register; a new item is
// still accepted, and a following tick waits at the end until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module formation_setpoint_generator
  import fsg_pkg::*;
#(
  parameter int MAX_DRONES   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire fsg_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output fsg_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_PSTART, S_PWAIT, S_ANGLE,
    S_CSTART, S_CWAIT, S_MSTART, S_MWAIT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic        pattern;
  logic [3:0]  drone_index;
  logic [4:0]  drone_count;
  logic [30:0] orbit_radius;
  logic [31:0] angular_rate;

  // target state
  logic               target_known;
  logic signed [31:0] stored_north;
  logic signed [31:0] stored_east;
  logic signed [31:0] stored_down;
  logic [15:0]        stored_heading;
  logic [47:0]        elapsed_us;

  // work registers
  logic [31:0]        phase;
  logic [15:0]        ang16;
  logic signed [33:0] z0;
  logic               flip;
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;
  logic [63:0]        acc;
  logic [1:0]         op;
  logic [31:0]        dn;
  logic [31:0]        de;

  // unit handshakes
  logic               div_done;
  logic [31:0]        div_quot;
  logic               mul_start;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic               mul_done;
  logic signed [67:0] mul_prod;
  logic               cor_done;
  logic signed [33:0] cor_cos;
  logic signed [33:0] cor_sin;

  logic               accept;
  logic [4:0]         cnt_eff;
  logic signed [6:0]  d;
  logic [5:0]         d_abs;
  logic signed [33:0] side;
  logic signed [33:0] fwd;
  logic               fresh;
  logic               sub;
  logic               take_dn;
  logic [1:0]         last_op;
  logic [63:0]        acc_sum;
  logic [31:0]        ph_sum;
  logic signed [16:0] a_s;
  logic signed [16:0] a_f;
  logic               flip_c;
  logic [14:0]        mag;
  logic [46:0]        zp;
  logic [31:0]        zmag;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;

  // effective count: zero reads as one, clamped to the formation size
  always_comb begin
    if (drone_count == 5'd0)
      cnt_eff = 5'd1;
    else if (int'(drone_count) > MAX_DRONES)
      cnt_eff = 5'(MAX_DRONES);
    else
      cnt_eff = drone_count;
  end

  // wedge offsets
  always_comb begin
    d     = 7'(signed'({2'b0, drone_index, 1'b0})) - 7'(signed'({2'b0, cnt_eff})) + 7'sd1;
    d_abs = d[6] ? 6'(-d) : 6'(d);
    side  = 34'(d) <<< 18;
    fwd   = (34'sd10 - 34'sd3 * 34'(signed'({1'b0, d_abs}))) <<< 16;
  end

  // operand and accumulate control per product
  always_comb begin
    last_op = pattern ? 2'd1 : 2'd3;
    fresh   = (op == 2'd0) || (pattern ? op == 2'd1 : op == 2'd2);
    sub     = !pattern && op == 2'd1;
    take_dn = pattern ? op == 2'd0 : op == 2'd1;
    if (state == S_PSTART) begin
      mul_a = 34'(signed'({2'b0, elapsed_us[31:0]}));
      mul_b = 34'(signed'({2'b0, angular_rate}));
    end else if (pattern) begin
      mul_a = 34'(signed'({3'b0, orbit_radius}));
      mul_b = op[0] ? sin_r : cos_r;
    end else begin
      case (op)
        2'd0:    begin mul_a = fwd;  mul_b = cos_r; end
        2'd1:    begin mul_a = side; mul_b = sin_r; end
        2'd2:    begin mul_a = fwd;  mul_b = sin_r; end
        default: begin mul_a = side; mul_b = cos_r; end
      endcase
    end
    mul_start = state == S_PSTART || state == S_MSTART;
    acc_sum   = sub ? acc - 64'(mul_prod) : acc + 64'(mul_prod);
    ph_sum    = acc_sum[31:0];
  end

  // angle fold to a half turn and scale to q30 radians
  always_comb begin
    a_s    = 17'(signed'(ang16));
    flip_c = 1'b0;
    a_f    = a_s;
    if (a_s > 17'sd16384) begin
      a_f    = a_s - 17'sd32768;
      flip_c = 1'b1;
    end else if (a_s < -17'sd16384) begin
      a_f    = a_s + 17'sd32768;
      flip_c = 1'b1;
    end
    mag  = a_f[16] ? 15'(-a_f) : 15'(a_f);
    zp   = 47'(mag) * 47'(PI_Q30) + 47'd16384;
    zmag = zp[46:15];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      pattern        <= 1'b1;
      drone_index    <= '0;
      drone_count    <= 5'd1;
      orbit_radius   <= '0;
      angular_rate   <= '0;
      target_known   <= 1'b0;
      stored_north   <= '0;
      stored_east    <= '0;
      stored_down    <= '0;
      stored_heading <= '0;
      elapsed_us     <= '0;
      op             <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT)
        out_valid <= 1'b0;

      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PATTERN:      pattern      <= cfg_data[0];
          CFG_DRONE_INDEX:  drone_index  <= cfg_data[3:0];
          CFG_DRONE_COUNT:  drone_count  <= cfg_data[4:0];
          CFG_ORBIT_RADIUS: orbit_radius <= cfg_data[30:0];
          CFG_ANGULAR_RATE: angular_rate <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              MODE_ACTIVATE: elapsed_us <= '0;
              MODE_TARGET: begin
                stored_north   <= in_data.target_north;
                stored_east    <= in_data.target_east;
                stored_down    <= in_data.target_down;
                stored_heading <= in_data.target_heading;
                target_known   <= 1'b1;
              end
              MODE_TICK: begin
                if (target_known) begin
                  elapsed_us <= elapsed_us + 48'(in_data.tick_us);
                  op         <= '0;
                  ang16      <= stored_heading;
                  state      <= pattern ? S_DSTART : S_ANGLE;
                end
              end
              default: ;
            endcase
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            phase <= div_quot;
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          acc   <= {32'd0, phase};
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (mul_done) begin
            ang16 <= ph_sum[31:16] + 16'(ph_sum[15]);
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          z0    <= a_f[16] ? -34'(signed'({2'b0, zmag})) : 34'(signed'({2'b0, zmag}));
          flip  <= flip_c;
          state <= S_CSTART;
        end
        S_CSTART: state <= S_CWAIT;
        S_CWAIT: begin
          if (cor_done) begin
            cos_r <= cor_cos;
            sin_r <= cor_sin;
            state <= S_MSTART;
          end
        end
        S_MSTART: begin
          if (fresh)
            acc <= 64'd1 << 29;
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            acc <= acc_sum;
            if (take_dn)
              dn <= acc_sum[61:30];
            if (op == last_op) begin
              state <= S_OUT;
              de    <= acc_sum[61:30];
            end else begin
              op    <= op + 2'd1;
              state <= S_MSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.set_north <= stored_north + signed'(dn);
            out_data.set_east  <= stored_east + signed'(de);
            out_data.set_down  <= stored_down - signed'(layer_of(drone_index));
            out_data.set_yaw   <= pattern ? signed'(ang16 ^ 16'h8000) : signed'(stored_heading);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fsg_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_DSTART),
    .idx  (drone_index),
    .cnt  (cnt_eff),
    .done (div_done),
    .quot (div_quot)
  );

  fsg_mult u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  fsg_cordic #(.STEPS(CORDIC_STEPS)) u_cor (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_CSTART),
    .z0     (z0),
    .flip   (flip),
    .done   (cor_done),
    .cos_q30(cor_cos),
    .sin_q30(cor_sin)
  );

  a_cor_in_wait: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == S_CWAIT) else $error("cordic result outside wait");
  a_mul_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MWAIT || state == S_PWAIT) else $error("stray product");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("result without tick");
  a_tick_needs_target: assert property (@(posedge clk) disable iff (rst)
    state == S_CWAIT |-> target_known) else $error("work without target");
endmodule
`default_nettype wire
